// File: rtl/mwc_bounded_random_unit_assert.svh
// ============================================================================
// Assertion macros for the bounded random unit
// Immediate-consequence and next-cycle property checks. They report through
// $error and compile to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef MWC_BOUNDED_RANDOM_UNIT_ASSERT_SVH
`define MWC_BOUNDED_RANDOM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define MWCBR_ASSERT_NOW(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (ante) |-> (cons)) else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define MWCBR_ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(reset_n)) \
        (ante) |=> (cons)) else $error("assertion failed");
`else
`define MWCBR_ASSERT_NOW(label, clock, reset_n, ante, cons)
`define MWCBR_ASSERT_NEXT(label, clock, reset_n, ante, cons)
`endif

`endif

// File: rtl/mwcbr_pkg.sv
// ============================================================================
// Bounded random unit package
// Item types, generator constants and status codes shared by the modules.
// ============================================================================
package mwcbr_pkg;

    localparam logic [31:0] MWC_MULT  = 32'd2131995753;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    localparam logic [1:0] ST_DRAWN  = 2'd0;
    localparam logic [1:0] ST_LOADED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic CFG_SEED_WORD  = 1'b0;
    localparam logic CFG_SEED_CARRY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] bound;
    } req_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } rsp_item_t;

endpackage

// File: rtl/mwc_bounded_random_unit.sv
// ============================================================================
// Bounded random unit
// Multiply-with-carry generator with seed loading and masked rejection
// sampling of a value below a 64-bit bound.
// ============================================================================
//
//   Channel   Direction  Handshake                 Payload
//   req       in         req_valid / req_stall     req_item  (req_type, bound)
//   rsp       out        rsp_valid / rsp_stall     rsp_item  (value, status)
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// A load request or a zero bound goes through the handoff state S_DONE to
// the output register. A draw with a bound below 2^32 passes S_HI and S_CMP
// for each candidate (generator step, compare); a wider bound passes S_HI,
// S_LO and S_CMP (high step, low step, compare), then S_DONE hands the item
// to the output. The single step unit and the 64-bit compare set these steps.
// Reset puts the generator at word 0, carry 1 and clears both seed registers.
// A stalled output holds its item; the next request is taken meanwhile and
// its result waits in the sequencer until the output register frees up.
module mwc_bounded_random_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mwcbr_pkg::req_item_t req_item,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mwcbr_pkg::rsp_item_t rsp_item,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);

`include "mwc_bounded_random_unit_assert.svh"

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HI   = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // All-ones mask covering the bit length of x.
    function automatic logic [31:0] len_mask(input logic [31:0] x);
        logic [31:0] m;
        begin
            m = x;
            m = m | (m >> 1);
            m = m | (m >> 2);
            m = m | (m >> 4);
            m = m | (m >> 8);
            m = m | (m >> 16);
            return m;
        end
    endfunction

    logic [2:0]  state_reg, state_next;
    logic [31:0] seed_word_reg, seed_carry_reg;
    logic [31:0] gen_word_reg, gen_word_next;
    logic [31:0] gen_carry_reg, gen_carry_next;
    logic [63:0] bound_reg, bound_next;
    logic [31:0] mask_reg, mask_next;
    logic        wide_reg, wide_next;
    logic        stuck_reg, stuck_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [63:0] res_value_reg, res_value_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        rsp_valid_reg, rsp_valid_next;
    mwcbr_pkg::rsp_item_t rsp_item_reg, rsp_item_next;

    logic [31:0] step_word, step_carry;
    logic        gen_stuck;
    logic [63:0] cand;
    logic        req_take;
    logic [31:0] load_carry;
    logic [31:0] bound_top;

    // The one shared generator step unit.
    mwcbr_step u_step
    (
        .word       (gen_word_reg),
        .carry      (gen_carry_reg),
        .next_word  (step_word),
        .next_carry (step_carry)
    );

    // The fixed point of the recurrence: stepping it gives the same pair.
    assign gen_stuck = (gen_word_reg == mwcbr_pkg::WORD_ONES)
                    && (gen_carry_reg == mwcbr_pkg::MWC_MULT - 32'd1);

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Seeds that would leave the generator degenerate get their carry bumped.
    always_comb
    begin
        load_carry = seed_carry_reg;
        if (((seed_word_reg == 32'd0) && (seed_carry_reg == 32'd0))
            || ((seed_word_reg == mwcbr_pkg::WORD_ONES)
                && (seed_carry_reg == mwcbr_pkg::MWC_MULT - 32'd1)))
        begin
            load_carry = seed_carry_reg + 32'd1;
        end
    end

    assign bound_top = (|req_item.bound[63:32]) ? req_item.bound[63:32]
                                                : req_item.bound[31:0];

    // A narrow candidate is one masked word; a wide one is masked high, raw low.
    assign cand = wide_reg ? {hi_reg, lo_reg} : {32'd0, hi_reg};

    always_comb
    begin
        state_next      = state_reg;
        gen_word_next   = gen_word_reg;
        gen_carry_next  = gen_carry_reg;
        bound_next      = bound_reg;
        mask_next       = mask_reg;
        wide_next       = wide_reg;
        stuck_next      = stuck_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_item_next   = rsp_item_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (req_item.req_type == mwcbr_pkg::REQ_LOAD)
                    begin
                        gen_word_next   = seed_word_reg;
                        gen_carry_next  = load_carry;
                        res_value_next  = 64'd0;
                        res_status_next = mwcbr_pkg::ST_LOADED;
                        state_next      = S_DONE;
                    end
                    else if (req_item.bound == 64'd0)
                    begin
                        res_value_next  = 64'd0;
                        res_status_next = mwcbr_pkg::ST_ERROR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        bound_next = req_item.bound;
                        wide_next  = |req_item.bound[63:32];
                        mask_next  = len_mask(bound_top);
                        state_next = S_HI;
                    end
                end
            end
            S_HI:
            begin
                // Note whether this candidate starts from the stuck pair.
                stuck_next     = gen_stuck;
                gen_word_next  = step_word;
                gen_carry_next = step_carry;
                hi_next        = step_word & mask_reg;
                state_next     = wide_reg ? S_LO : S_CMP;
            end
            S_LO:
            begin
                gen_word_next  = step_word;
                gen_carry_next = step_carry;
                lo_next        = step_word;
                state_next     = S_CMP;
            end
            S_CMP:
            begin
                if (cand < bound_reg)
                begin
                    res_value_next  = cand;
                    res_status_next = mwcbr_pkg::ST_DRAWN;
                    state_next      = S_DONE;
                end
                else if (stuck_reg)
                begin
                    // Every further candidate would be the same reject.
                    res_value_next  = 64'd0;
                    res_status_next = mwcbr_pkg::ST_ERROR;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_HI;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_item_next.value  = res_value_reg;
                    rsp_item_next.status = res_status_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rsp_valid_reg  <= 1'b0;
            seed_word_reg  <= 32'd0;
            seed_carry_reg <= 32'd0;
            gen_word_reg   <= 32'd0;
            gen_carry_reg  <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            gen_word_reg  <= gen_word_next;
            gen_carry_reg <= gen_carry_next;
            if (cfg_we)
            begin
                if (cfg_index == mwcbr_pkg::CFG_SEED_WORD)
                begin
                    seed_word_reg <= cfg_data;
                end
                if (cfg_index == mwcbr_pkg::CFG_SEED_CARRY)
                begin
                    seed_carry_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg      <= bound_next;
        mask_reg       <= mask_next;
        wide_reg       <= wide_next;
        stuck_reg      <= stuck_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        rsp_item_reg   <= rsp_item_next;
    end

    // Conditions named for the checks below.
    logic chk_drawn_wait;
    logic chk_load_take;
    logic chk_loaded_wait;
    logic chk_status_ok;

    assign chk_drawn_wait  = (state_reg == S_DONE)
                          && (res_status_reg == mwcbr_pkg::ST_DRAWN);
    assign chk_load_take   = req_take && (req_item.req_type == mwcbr_pkg::REQ_LOAD);
    assign chk_loaded_wait = (state_reg == S_DONE)
                          && (res_status_reg == mwcbr_pkg::ST_LOADED);
    assign chk_status_ok   = (rsp_item.status == mwcbr_pkg::ST_DRAWN)
                          || (rsp_item.status == mwcbr_pkg::ST_LOADED)
                          || (rsp_item.status == mwcbr_pkg::ST_ERROR);

    // A drawn value waiting for the output lies below the bound it answers.
    `MWCBR_ASSERT_NOW(a_drawn_below_bound, clk, rst_n, chk_drawn_wait, res_value_reg < bound_reg)

    // The generator never sits at the all-zero pair.
    `MWCBR_ASSERT_NOW(a_gen_not_zero, clk, rst_n, gen_word_reg == 32'd0, gen_carry_reg != 32'd0)

    // A load waits at the handoff state in the cycle after it is taken.
    `MWCBR_ASSERT_NEXT(a_load_done, clk, rst_n, chk_load_take, chk_loaded_wait)

    // Every item shown at the output carries a defined status.
    `MWCBR_ASSERT_NOW(a_status_defined, clk, rst_n, rsp_valid, chk_status_ok)

endmodule

// File: rtl/mwcbr_step.sv
// ============================================================================
// Multiply-with-carry step
// Forms MWC_MULT * word + carry and splits it into the next word and carry.
// ============================================================================
module mwcbr_step
(
    input  logic [31:0] word,
    input  logic [31:0] carry,
    output logic [31:0] next_word,
    output logic [31:0] next_carry
);

    logic [63:0] prod;

    // The sum cannot overflow: (2^32-1)*M + 2^32-1 < 2^64.
    assign prod       = {32'd0, mwcbr_pkg::MWC_MULT} * {32'd0, word} + {32'd0, carry};
    assign next_word  = prod[31:0];
    assign next_carry = prod[63:32];

endmodule

// File: tb/tb_mwc_bounded_random_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Bounded random unit testbench
// Drives load and draw requests through the valid/stall request channel,
// rewrites the seed registers between phases, and checks every response
// against a cycle-free predictor of the multiply-with-carry generator and
// its masked rejection sampling. A directed table comes first, followed by
// randomized phases with bursty requests and a response side that stalls.
// ============================================================================
module tb_mwc_bounded_random_unit;

    // Seed pairs that exercise the load repair and the stuck generator.
    localparam logic [31:0] STUCK_CARRY     = mwcbr_pkg::MWC_MULT - 32'd1;
    localparam logic [31:0] PRE_STUCK_WORD  = 32'hFFFF_FFFE;
    localparam logic [31:0] PRE_STUCK_CARRY = 32'd4263991505;

    localparam int RANDOM_ITEMS = 1125;
    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 20;

    typedef enum logic {ROW_SEED, ROW_REQ} row_kind_t;

    // One row of the directed table. A seed row rewrites both seed registers
    // while the unit is idle; a request row sends one item, and where the
    // answer is obvious it carries that answer directly.
    typedef struct {
        row_kind_t            kind;
        mwcbr_pkg::req_item_t item;
        logic [31:0]          seed_word;
        logic [31:0]          seed_carry;
        logic                 known;
        mwcbr_pkg::rsp_item_t known_rsp;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    mwcbr_pkg::req_item_t req_item = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    mwcbr_pkg::rsp_item_t rsp_item;
    logic        cfg_we = 1'b0;
    logic        cfg_index = mwcbr_pkg::CFG_SEED_WORD;
    logic [31:0] cfg_data = '0;

    // Side information that travels with the request currently on the bus.
    logic                 req_known = 1'b0;
    mwcbr_pkg::rsp_item_t req_known_rsp = '0;

    // Predictor copy of the seed registers and the generator.
    logic [31:0] model_seed_word = '0;
    logic [31:0] model_seed_carry = '0;
    logic [31:0] model_gen_word = '0;
    logic [31:0] model_gen_carry = 32'd1;

    mwcbr_pkg::rsp_item_t awaited_rsp_q[$];
    stim_row_t            directed_rows[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int drawn_results = 0;
    int loaded_results = 0;
    int rejected_results = 0;
    int wide_draws = 0;
    int seed_settings = 0;
    int burst_left = 0;
    int quiet_cycles = 0;

    mwc_bounded_random_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // All-ones mask that covers the bit length of x.
    function automatic logic [31:0] length_mask(logic [31:0] x);
        logic [31:0] mask;
        mask = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                mask = (i == 31) ? mwcbr_pkg::WORD_ONES : ((32'd1 << (i + 1)) - 32'd1);
            end
        end
        return mask;
    endfunction

    // One generator step: the low half of the product becomes the new word
    // (and the output), the high half becomes the new carry.
    function automatic logic [31:0] mwc_advance();
        logic [63:0] product;
        product = {32'd0, mwcbr_pkg::MWC_MULT} * {32'd0, model_gen_word}
                + {32'd0, model_gen_carry};
        model_gen_word = product[31:0];
        model_gen_carry = product[63:32];
        return model_gen_word;
    endfunction

    // Works out the response to one request and moves the generator along.
    function automatic mwcbr_pkg::rsp_item_t compute_draw_result(mwcbr_pkg::req_item_t it);
        mwcbr_pkg::rsp_item_t result;
        logic [31:0]          carry;
        logic [31:0]          mask;
        logic [31:0]          high_word;
        logic [63:0]          candidate;
        logic                 narrow;
        logic                 was_stuck;
        result.value = '0;
        result.status = mwcbr_pkg::ST_ERROR;
        if (it.req_type == mwcbr_pkg::REQ_LOAD)
        begin
            // The all-zero pair and the fixed point get their carry bumped.
            carry = model_seed_carry;
            if ((model_seed_word == '0 && model_seed_carry == '0) ||
                (model_seed_word == mwcbr_pkg::WORD_ONES && model_seed_carry == STUCK_CARRY))
            begin
                carry = carry + 32'd1;
            end
            model_gen_word = model_seed_word;
            model_gen_carry = carry;
            result.status = mwcbr_pkg::ST_LOADED;
        end
        else if (it.bound != '0)
        begin
            narrow = (it.bound[63:32] == '0);
            mask = narrow ? length_mask(it.bound[31:0])
                          : length_mask(it.bound[63:32]);
            while (1)
            begin
                was_stuck = (model_gen_word == mwcbr_pkg::WORD_ONES
                             && model_gen_carry == STUCK_CARRY);
                if (narrow)
                begin
                    candidate = {32'd0, mwc_advance() & mask};
                end
                else
                begin
                    high_word = mwc_advance() & mask;
                    candidate = {high_word, mwc_advance()};
                end
                if (candidate < it.bound)
                begin
                    result.value = candidate;
                    result.status = mwcbr_pkg::ST_DRAWN;
                    break;
                end
                // From the fixed point every later candidate is the same one.
                if (was_stuck)
                begin
                    break;
                end
            end
        end
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and checker. Everything is sampled at the rising edge, before
    // the nonblocking updates of that edge take effect.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        mwcbr_pkg::rsp_item_t predicted;
        mwcbr_pkg::rsp_item_t awaited;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == mwcbr_pkg::CFG_SEED_WORD)
                begin
                    model_seed_word = cfg_data;
                end
                else
                begin
                    model_seed_carry = cfg_data;
                end
            end
            if (req_valid && !req_stall)
            begin
                predicted = compute_draw_result(req_item);
                awaited_rsp_q.push_back(req_known ? req_known_rsp : predicted);
                if (req_item.req_type == mwcbr_pkg::REQ_DRAW && req_item.bound[63:32] != '0)
                begin
                    wide_draws++;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response, value %h status %0d",
                             $time, rsp_item.value, rsp_item.status);
                    mismatch_count++;
                end
                else
                begin
                    awaited = awaited_rsp_q.pop_front();
                    if (rsp_item.value !== awaited.value)
                    begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, awaited.value, rsp_item.value);
                        mismatch_count++;
                    end
                    if (rsp_item.status !== awaited.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, awaited.status, rsp_item.status);
                        mismatch_count++;
                    end
                    case (awaited.status)
                        mwcbr_pkg::ST_DRAWN:  drawn_results++;
                        mwcbr_pkg::ST_LOADED: loaded_results++;
                        default:              rejected_results++;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch with no item moving on either channel means
    // the unit has hung.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d responses outstanding",
                     $time, QUIET_LIMIT, awaited_rsp_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: the stall pattern switches between free running, light
    // and heavy random stalling, and long stall holds.
    // ------------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    rsp_stall <= !rsp_stall;
                    hold_left <= rsp_stall ? $urandom_range(0, 3) : $urandom_range(2, 12);
                end
                else
                begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic void add_seed_row(logic [31:0] word, logic [31:0] carry);
        stim_row_t row;
        row.kind = ROW_SEED;
        row.item = '0;
        row.seed_word = word;
        row.seed_carry = carry;
        row.known = 1'b0;
        row.known_rsp = '0;
        directed_rows.push_back(row);
    endfunction

    // A request row; known_status of ST_LOADED, ST_DRAWN or ST_ERROR together
    // with known set gives the answer that the row must produce.
    function automatic void add_req_row(logic kind, logic [63:0] bound, logic known,
                                        logic [63:0] known_value, logic [1:0] known_status);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.item.req_type = kind;
        row.item.bound = bound;
        row.seed_word = '0;
        row.seed_carry = '0;
        row.known = known;
        row.known_rsp.value = known_value;
        row.known_rsp.status = known_status;
        directed_rows.push_back(row);
    endfunction

    // Presents one item and returns at the edge where it is taken. The valid
    // stays high, so a following item can go out back to back.
    task automatic drive_req(mwcbr_pkg::req_item_t it, logic known,
                             mwcbr_pkg::rsp_item_t known_rsp);
        req_valid <= 1'b1;
        req_item <= it;
        req_known <= known;
        req_known_rsp <= known_rsp;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Holds off until every response in flight has come back. The queue is
    // looked at on the falling edge, after the monitor has run.
    task automatic drain_block();
        req_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (awaited_rsp_q.size() != 0);
        @(posedge clk);
    endtask

    // Writes the seed word register and then the seed carry register; only
    // called once the unit has gone idle.
    task automatic write_seeds(logic [31:0] word, logic [31:0] carry);
        cfg_we <= 1'b1;
        cfg_index <= mwcbr_pkg::CFG_SEED_WORD;
        cfg_data <= word;
        @(posedge clk);
        cfg_index <= mwcbr_pkg::CFG_SEED_CARRY;
        cfg_data <= carry;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_settings++;
    endtask

    // Bursty sender: after a burst of random length it drops valid for a
    // random gap, and now and then waits for the unit to empty completely.
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 39) == 0)
            begin
                drain_block();
            end
            else
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    // Bound for a random draw, spread over zero, short and long bit lengths,
    // powers of two and their neighbors, and bounds above 32 bits.
    function automatic logic [63:0] random_bound();
        logic [63:0] b;
        logic [31:0] high_part;
        int unsigned k;
        case ($urandom_range(0, 19))
            0: b = '0;
            1, 2, 3, 4, 5, 6: b = 64'($urandom_range(1, 300));
            7, 8, 9, 10: b = {32'd0, $urandom() >> $urandom_range(0, 31)};
            11:
            begin
                k = $urandom_range(0, 31);
                b = (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
            end
            12, 13, 14, 15, 16:
            begin
                high_part = $urandom() >> $urandom_range(0, 31);
                if (high_part == '0)
                begin
                    high_part = 32'd1;
                end
                b = {high_part, $urandom()};
            end
            17:
            begin
                k = $urandom_range(32, 63);
                b = (64'd1 << k) + 64'($urandom_range(0, 2)) - 64'd1;
            end
            18: b = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
            default: b = {$urandom(), $urandom()};
        endcase
        return b;
    endfunction

    initial
    begin
        stim_row_t            row;
        mwcbr_pkg::req_item_t it;
        mwcbr_pkg::rsp_item_t no_answer;
        logic [31:0]          word;
        logic [31:0]          carry;
        int                   random_sent;
        int                   phase_left;

        no_answer = '0;
        random_sent = 0;
        phase_left = 0;

        // Directed table. Straight after reset the generator sits at word 0,
        // carry 1, so the first step yields 1.
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'd2, 1'b1, 64'd1, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'd0, 1'b1, 64'd0, mwcbr_pkg::ST_ERROR);
        // Load from the cleared seeds: the all-zero pair is repaired.
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                    64'd0, mwcbr_pkg::ST_LOADED);
        // Full-range wide draw from word 0, carry 1: high word 1, low word
        // equal to the multiplier.
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                    {32'd1, mwcbr_pkg::MWC_MULT}, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'd1, 1'b0, '0, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0001_0000_0000, 1'b0,
                    '0, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0000_FFFF_FFFF, 1'b0,
                    '0, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h8000_0000_0000_0000, 1'b0,
                    '0, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h8000_0000_0000_0001, 1'b0,
                    '0, mwcbr_pkg::ST_DRAWN);
        // Seeding with the fixed point itself gets the carry repaired.
        add_seed_row(mwcbr_pkg::WORD_ONES, STUCK_CARRY);
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'd0, 1'b1, 64'd0, mwcbr_pkg::ST_LOADED);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'd3, 1'b0, '0, mwcbr_pkg::ST_DRAWN);
        // This unrepaired seed steps straight into the fixed point, after
        // which every candidate is rejected, narrow or wide.
        add_seed_row(PRE_STUCK_WORD, PRE_STUCK_CARRY);
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'd77, 1'b1, 64'd0, mwcbr_pkg::ST_LOADED);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'd5, 1'b1, 64'd0, mwcbr_pkg::ST_ERROR);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0000_8000_0000, 1'b1,
                    64'd0, mwcbr_pkg::ST_ERROR);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0000_FFFF_FFFF, 1'b1,
                    64'd0, mwcbr_pkg::ST_ERROR);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0001_0000_0000, 1'b1,
                    64'd0, mwcbr_pkg::ST_ERROR);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                    64'd0, mwcbr_pkg::ST_ERROR);
        add_seed_row(mwcbr_pkg::WORD_ONES, mwcbr_pkg::WORD_ONES);
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'd1, 1'b1, 64'd0, mwcbr_pkg::ST_LOADED);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'hFFFF_FFFF_0000_0000, 1'b0,
                    '0, mwcbr_pkg::ST_DRAWN);
        // An explicitly written zero seed behaves like the reset state.
        add_seed_row(32'd0, 32'd0);
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'd0, 1'b1, 64'd0, mwcbr_pkg::ST_LOADED);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'd2, 1'b1, 64'd1, mwcbr_pkg::ST_DRAWN);
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'h0000_0000_FFFF_FFFF, 1'b1,
                    64'd0, mwcbr_pkg::ST_LOADED);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0000_FFFF_FFFF, 1'b1,
                    64'd1, mwcbr_pkg::ST_DRAWN);
        add_seed_row(32'd0, mwcbr_pkg::WORD_ONES);
        add_req_row(mwcbr_pkg::REQ_LOAD, 64'd0, 1'b1, 64'd0, mwcbr_pkg::ST_LOADED);
        add_req_row(mwcbr_pkg::REQ_DRAW, 64'h0000_0001_FFFF_FFFF, 1'b0,
                    '0, mwcbr_pkg::ST_DRAWN);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_SEED)
            begin
                drain_block();
                write_seeds(row.seed_word, row.seed_carry);
            end
            else
            begin
                drive_req(row.item, row.known, row.known_rsp);
                pace_sender();
            end
        end

        // Random phases. Each phase waits for the unit to empty, writes a new
        // seed pair (random most of the time, otherwise an extreme or one of
        // the degenerate pairs) and usually starts by loading it.
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 9))
                    6:
                    begin
                        word = '0;
                        carry = '0;
                    end
                    7:
                    begin
                        word = $urandom_range(0, 1) ? mwcbr_pkg::WORD_ONES : 32'd0;
                        carry = $urandom_range(0, 1) ? mwcbr_pkg::WORD_ONES : 32'd0;
                    end
                    8:
                    begin
                        word = mwcbr_pkg::WORD_ONES;
                        carry = STUCK_CARRY;
                    end
                    9:
                    begin
                        word = PRE_STUCK_WORD;
                        carry = PRE_STUCK_CARRY;
                    end
                    default:
                    begin
                        word = $urandom();
                        carry = $urandom();
                    end
                endcase
                drain_block();
                write_seeds(word, carry);
                phase_left = $urandom_range(40, 160);
                if ($urandom_range(0, 4) != 0)
                begin
                    it.req_type = mwcbr_pkg::REQ_LOAD;
                    it.bound = {$urandom(), $urandom()};
                    drive_req(it, 1'b0, no_answer);
                    random_sent++;
                    pace_sender();
                end
            end
            it.req_type = ($urandom_range(0, 11) == 0) ? mwcbr_pkg::REQ_LOAD
                                                       : mwcbr_pkg::REQ_DRAW;
            it.bound = random_bound();
            drive_req(it, 1'b0, no_answer);
            random_sent++;
            phase_left--;
            pace_sender();
        end

        // Let everything in flight come back, then give the unit time to show
        // any response that should not exist.
        drain_block();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d seed settings (%0d wide-bound draws).",
                 items_sent, seed_settings, wide_draws);
        $display("Responses: %0d values drawn, %0d loads, %0d rejected requests.",
                 drawn_results, loaded_results, rejected_results);
        if (mismatch_count == 0 && awaited_rsp_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/mwcbr_pkg.sv
rtl/mwcbr_step.sv
rtl/mwc_bounded_random_unit.sv
tb/tb_mwc_bounded_random_unit.sv
